### hdl/scrypt_romix_salsa20_8_core_assert.svh
// Assertion macros for the scrypt ROMix core.
// Used by the controller; expects clk and rst_n in scope.
`ifndef SCRYPT_ROMIX_SALSA20_8_CORE_ASSERT_SVH
`define SCRYPT_ROMIX_SALSA20_8_CORE_ASSERT_SVH

// Same-cycle implication.
`define SRM_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SRM_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### hdl/srm_pkg.sv
// Shared types, constants and Salsa20/8 round functions for the ROMix core.
// No dependencies.
package srm_pkg;

    localparam int DEF_BLOCK_FACTOR = 1;
    localparam int DEF_MAX_LOG_N    = 10;
    localparam int SUB_WORDS        = 16;
    localparam int LOG_N_W          = 4;
    localparam logic [LOG_N_W-1:0] LOG_N_RESET = 4'd10;

    localparam int ROT_A = 7;
    localparam int ROT_B = 9;
    localparam int ROT_C = 13;
    localparam int ROT_D = 18;

    typedef logic [31:0] word_t;
    typedef logic [SUB_WORDS-1:0][31:0] sblk_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_STORE,
        ST_JLATCH,
        ST_XOR,
        ST_MINIT,
        ST_SLOAD,
        ST_ROUND,
        ST_SADD,
        ST_COPY,
        ST_OUT
    } state_t;

    typedef enum logic {
        PASS_FILL,
        PASS_MIX
    } pass_t;

    typedef struct packed {
        logic load_shift;
        logic store;
        logic mem_rd;
        logic jlatch;
        logic s_init;
        logic s_load;
        logic s_round;
        logic s_add;
        logic copy;
        logic out_rot;
    } cmd_t;

    function automatic word_t rotl(word_t v, int c);
        return (v << c) | (v >> (32 - c));
    endfunction

    function automatic sblk_t quarter(sblk_t w, int a, int b, int c, int d);
        sblk_t r;
        r = w;
        r[b] = r[b] ^ rotl(word_t'(r[a] + r[d]), ROT_A);
        r[c] = r[c] ^ rotl(word_t'(r[b] + r[a]), ROT_B);
        r[d] = r[d] ^ rotl(word_t'(r[c] + r[b]), ROT_C);
        r[a] = r[a] ^ rotl(word_t'(r[d] + r[c]), ROT_D);
        return r;
    endfunction

    function automatic sblk_t double_round(sblk_t w);
        sblk_t r;
        r = w;
        r = quarter(r, 0, 4, 8, 12);
        r = quarter(r, 5, 9, 13, 1);
        r = quarter(r, 10, 14, 2, 6);
        r = quarter(r, 15, 3, 7, 11);
        r = quarter(r, 0, 1, 2, 3);
        r = quarter(r, 5, 6, 7, 4);
        r = quarter(r, 10, 11, 8, 9);
        r = quarter(r, 15, 12, 13, 14);
        return r;
    endfunction

endpackage

### hdl/srm_dp.sv
// Datapath of the ROMix core: block registers, Salsa20/8 unit, scratch memory.
// Depends on srm_pkg; driven by srm_ctrl.
module srm_dp #(
    parameter int BLOCK_FACTOR = srm_pkg::DEF_BLOCK_FACTOR,
    parameter int MAX_LOG_N    = srm_pkg::DEF_MAX_LOG_N
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  srm_pkg::cmd_t                                cmd,
    input  logic [$clog2(32*BLOCK_FACTOR)-1:0]           word_idx,
    input  logic [$clog2(2*BLOCK_FACTOR)-1:0]            sub_idx,
    input  logic [MAX_LOG_N-1:0]                         round_idx,
    input  logic [MAX_LOG_N-1:0]                         n_mask,
    input  logic [31:0]                                  in_word,
    output logic [31:0]                                  out_word
);
    import srm_pkg::*;

    localparam int BLK   = 32 * BLOCK_FACTOR;
    localparam int NSUB  = 2 * BLOCK_FACTOR;
    localparam int WORDW = $clog2(BLK);
    localparam int SUBW  = $clog2(NSUB);
    localparam int AW    = MAX_LOG_N + WORDW;
    localparam int DEPTH = 1 << AW;

    word_t x_reg [BLK];
    sblk_t y_reg [NSUB];
    sblk_t s_reg;
    sblk_t t_reg;
    sblk_t x_head;
    sblk_t x_tail;
    sblk_t s_sum;
    word_t mem [DEPTH];
    word_t rd_reg;
    logic  rd_valid_reg;
    logic [MAX_LOG_N-1:0] j_reg;
    logic [AW-1:0] addr;
    logic [SUBW-1:0] dst;

    always_comb
    begin
        for (int k = 0; k < SUB_WORDS; k++)
        begin
            x_head[k] = x_reg[k];
            x_tail[k] = x_reg[BLK - SUB_WORDS + k];
            s_sum[k]  = word_t'(s_reg[k] + t_reg[k]);
        end
    end

    assign addr = {(cmd.mem_rd ? j_reg : round_idx), word_idx};
    assign dst  = sub_idx[0] ? SUBW'(BLOCK_FACTOR) + (sub_idx >> 1) : (sub_idx >> 1);
    assign out_word = x_reg[0];

    // scratch memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[addr] <= x_reg[0];
        end
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.mem_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.jlatch)
        begin
            j_reg <= x_reg[(NSUB - 1) * SUB_WORDS][MAX_LOG_N-1:0] & n_mask;
        end
    end

    // block register: shift, rotate, fold in scratch data, reload from y
    always_ff @(posedge clk)
    begin
        if (cmd.load_shift)
        begin
            for (int k = 0; k < BLK - 1; k++)
            begin
                x_reg[k] <= x_reg[k + 1];
            end
            x_reg[BLK-1] <= in_word;
        end
        else if (rd_valid_reg)
        begin
            for (int k = 0; k < BLK - 1; k++)
            begin
                x_reg[k] <= x_reg[k + 1];
            end
            x_reg[BLK-1] <= x_reg[0] ^ rd_reg;
        end
        else if (cmd.store || cmd.out_rot)
        begin
            for (int k = 0; k < BLK; k++)
            begin
                x_reg[k] <= x_reg[(k + 1) & (BLK - 1)];
            end
        end
        else if (cmd.s_load)
        begin
            for (int k = 0; k < BLK; k++)
            begin
                x_reg[k] <= x_reg[(k + SUB_WORDS) & (BLK - 1)];
            end
        end
        else if (cmd.copy)
        begin
            for (int k = 0; k < BLK; k++)
            begin
                x_reg[k] <= y_reg[k >> 4][k & (SUB_WORDS - 1)];
            end
        end
    end

    // Salsa20/8: one double round per cycle, feed-forward add at the end
    always_ff @(posedge clk)
    begin
        if (cmd.s_init)
        begin
            s_reg <= x_tail;
        end
        else if (cmd.s_load)
        begin
            s_reg <= s_reg ^ x_head;
            t_reg <= s_reg ^ x_head;
        end
        else if (cmd.s_round)
        begin
            t_reg <= double_round(t_reg);
        end
        else if (cmd.s_add)
        begin
            s_reg <= s_sum;
            y_reg[dst] <= s_sum;
        end
    end

endmodule

### hdl/srm_ctrl.sv
// Controller of the ROMix core: sequences load, both passes and output.
// Depends on srm_pkg and scrypt_romix_salsa20_8_core_assert.svh.
module srm_ctrl #(
    parameter int BLOCK_FACTOR = srm_pkg::DEF_BLOCK_FACTOR,
    parameter int MAX_LOG_N    = srm_pkg::DEF_MAX_LOG_N
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  cfg_we,
    input  logic [srm_pkg::LOG_N_W-1:0]           cfg_data,
    output logic                                  busy,
    output logic                                  out_valid,
    output logic                                  last_word,
    output srm_pkg::cmd_t                         cmd,
    output logic [$clog2(32*BLOCK_FACTOR)-1:0]    word_idx,
    output logic [$clog2(2*BLOCK_FACTOR)-1:0]     sub_idx,
    output logic [MAX_LOG_N-1:0]                  round_idx,
    output logic [MAX_LOG_N-1:0]                  n_mask
);
    import srm_pkg::*;

    localparam int BLK   = 32 * BLOCK_FACTOR;
    localparam int NSUB  = 2 * BLOCK_FACTOR;
    localparam int WORDW = $clog2(BLK);
    localparam int SUBW  = $clog2(NSUB);

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;
    logic [WORDW:0]         cnt_reg, cnt_next;
    logic [SUBW-1:0]        sub_reg, sub_next;
    logic [1:0]             dr_reg, dr_next;
    logic [MAX_LOG_N-1:0]   round_reg, round_next;
    logic [MAX_LOG_N-1:0]   mask_reg, mask_next;
    logic [LOG_N_W-1:0]     log_n_reg;
    logic [MAX_LOG_N-1:0]   mask_calc;

    // clamp log_n to 1..MAX_LOG_N and turn it into N-1
    always_comb
    begin
        int ln;
        ln = int'(log_n_reg);
        if (ln < 1)
        begin
            ln = 1;
        end
        if (ln > MAX_LOG_N)
        begin
            ln = MAX_LOG_N;
        end
        for (int b = 0; b < MAX_LOG_N; b++)
        begin
            mask_calc[b] = (b < ln);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_n_reg <= LOG_N_RESET;
        end
        else if (cfg_we)
        begin
            log_n_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            pass_reg  <= PASS_FILL;
            cnt_reg   <= '0;
            sub_reg   <= '0;
            dr_reg    <= '0;
            round_reg <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            dr_reg    <= dr_next;
            round_reg <= round_next;
            mask_reg  <= mask_next;
        end
    end

    assign word_idx  = cnt_reg[WORDW-1:0];
    assign sub_idx   = sub_reg;
    assign round_idx = round_reg;
    assign n_mask    = mask_reg;
    assign busy      = (state_reg != ST_LOAD);

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        dr_next    = dr_reg;
        round_next = round_reg;
        mask_next  = mask_reg;
        cmd        = '0;
        out_valid  = 1'b0;
        last_word  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    cmd.load_shift = 1'b1;
                    if (cnt_reg == (WORDW+1)'(BLK - 1))
                    begin
                        cnt_next   = '0;
                        round_next = '0;
                        pass_next  = PASS_FILL;
                        mask_next  = mask_calc;
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (cnt_reg == (WORDW+1)'(BLK - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_JLATCH:
            begin
                cmd.jlatch = 1'b1;
                cnt_next   = '0;
                state_next = ST_XOR;
            end
            ST_XOR:
            begin
                // issue reads for BLK words; the last one lands in the following cycle
                cmd.mem_rd = !cnt_reg[WORDW];
                if (cnt_reg[WORDW])
                begin
                    cnt_next   = '0;
                    state_next = ST_MINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MINIT:
            begin
                cmd.s_init = 1'b1;
                sub_next   = '0;
                state_next = ST_SLOAD;
            end
            ST_SLOAD:
            begin
                cmd.s_load = 1'b1;
                dr_next    = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.s_round = 1'b1;
                dr_next     = dr_reg + 1'b1;
                if (dr_reg == 2'd3)
                begin
                    state_next = ST_SADD;
                end
            end
            ST_SADD:
            begin
                cmd.s_add = 1'b1;
                if (sub_reg == SUBW'(NSUB - 1))
                begin
                    state_next = ST_COPY;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = ST_SLOAD;
                end
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                cnt_next = '0;
                if (round_reg == mask_reg)
                begin
                    round_next = '0;
                    if (pass_reg == PASS_FILL)
                    begin
                        pass_next  = PASS_MIX;
                        state_next = ST_JLATCH;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                    state_next = (pass_reg == PASS_FILL) ? ST_STORE : ST_JLATCH;
                end
            end
            ST_OUT:
            begin
                cmd.out_rot = 1'b1;
                out_valid   = 1'b1;
                if (cnt_reg == (WORDW+1)'(BLK - 1))
                begin
                    last_word  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `include "scrypt_romix_salsa20_8_core_assert.svh"

    `SRM_ASSERT_NOW(a_out_busy, out_valid, busy)
    `SRM_ASSERT_NEXT(a_last_idle, out_valid && last_word, !busy && cnt_reg == '0)
    `SRM_ASSERT_NOW(a_busy_rise, $rose(busy), $past(start) && $past(cnt_reg) == (WORDW+1)'(BLK - 1))
    `SRM_ASSERT_NOW(a_rd_in_mix, cmd.mem_rd, pass_reg == PASS_MIX)

endmodule

### hdl/scrypt_romix_salsa20_8_core.sv
// scrypt ROMix core over BlockMix/Salsa20-8. Feed one block of 32*BLOCK_FACTOR
// words with start while busy is low; after the last word busy rises and the
// core runs N = 2^log_n fill rounds and N mix rounds. Each fill round does a
// word-wide scratch write, then 2R Salsa20/8 cores at one double round per
// cycle; each mix round latches the index, does a word-wide registered scratch
// read, then runs the same Salsa20/8 cores. The mixed block then leaves as 32R
// words, one per cycle on out_valid, with last_word on the final one; the
// receiver cannot stall, so the words must be taken as they appear. The user
// writes log_n through cfg_we only while busy is low; the core does not enforce
// this. 0 acts as 1 and values above MAX_LOG_N saturate.
// Depends on srm_pkg, srm_ctrl, srm_dp.
module scrypt_romix_salsa20_8_core #(
    parameter int BLOCK_FACTOR = srm_pkg::DEF_BLOCK_FACTOR,
    parameter int MAX_LOG_N    = srm_pkg::DEF_MAX_LOG_N
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   in_word,
    input  logic                          cfg_we,
    input  logic [srm_pkg::LOG_N_W-1:0]   cfg_data,
    output logic                          out_valid,
    output logic [31:0]                   out_word,
    output logic                          last_word
);
    import srm_pkg::*;

    localparam int WORDW = $clog2(32 * BLOCK_FACTOR);
    localparam int SUBW  = $clog2(2 * BLOCK_FACTOR);

    cmd_t                 cmd;
    logic [WORDW-1:0]     word_idx;
    logic [SUBW-1:0]      sub_idx;
    logic [MAX_LOG_N-1:0] round_idx;
    logic [MAX_LOG_N-1:0] n_mask;

    srm_ctrl #(
        .BLOCK_FACTOR (BLOCK_FACTOR),
        .MAX_LOG_N    (MAX_LOG_N)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .out_valid (out_valid),
        .last_word (last_word),
        .cmd       (cmd),
        .word_idx  (word_idx),
        .sub_idx   (sub_idx),
        .round_idx (round_idx),
        .n_mask    (n_mask)
    );

    srm_dp #(
        .BLOCK_FACTOR (BLOCK_FACTOR),
        .MAX_LOG_N    (MAX_LOG_N)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .word_idx  (word_idx),
        .sub_idx   (sub_idx),
        .round_idx (round_idx),
        .n_mask    (n_mask),
        .in_word   (in_word),
        .out_word  (out_word)
    );

endmodule
